/* sv/i2c_mts_pkg.sv */
package i2c_mts_pkg;

  // Width of the byte counter of one message
  localparam int unsigned LENGTH_WIDTH = 16;

  // Field widths
  localparam int unsigned FuncW     = 2;
  localparam int unsigned AddrW     = 7;
  localparam int unsigned MsgLenW   = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned RetryW    = 4;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned CfgIndexW = 1;
  localparam int unsigned CfgDataW  = 4;

  // Configuration register indexes and reset values
  localparam logic [CfgIndexW-1:0] CfgRepeatedStart = 1'd0;
  localparam logic [CfgIndexW-1:0] CfgRetryLimit    = 1'd1;
  localparam logic                 RepeatedStartRst = 1'b1;
  localparam logic [RetryW-1:0]    RetryLimitRst    = 4'd5;

  // Core command register bits
  localparam logic [ByteW-1:0] CmdStart = 8'h81;
  localparam logic [ByteW-1:0] CmdStop  = 8'h41;
  localparam logic [ByteW-1:0] CmdRead  = 8'h21;
  localparam logic [ByteW-1:0] CmdWrite = 8'h11;
  localparam logic [ByteW-1:0] CmdAck   = 8'h08;

  typedef enum logic [FuncW-1:0] {
    FuncBegin   = 2'd0,
    FuncTxByte  = 2'd1,
    FuncCmdDone = 2'd2,
    FuncTimeout = 2'd3
  } func_e;

  typedef enum logic [StatusW-1:0] {
    StOk         = 3'd0,
    StAddrNak    = 3'd1,
    StDataNak    = 3'd2,
    StTimeout    = 3'd3,
    StUnexpected = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    PhIdle       = 4'd0,
    PhNext       = 4'd1,
    PhAddr       = 4'd2,
    PhAddrStop   = 4'd3,
    PhWrNeed     = 4'd4,
    PhWrWait     = 4'd5,
    PhWrNakStop  = 4'd6,
    PhRdWait     = 4'd7,
    PhMsgStop    = 4'd8
  } phase_e;

  // One input word
  typedef struct packed {
    func_e              func;
    logic [AddrW-1:0]   device_address;
    logic               read_flag;
    logic [MsgLenW-1:0] message_length;
    logic               final_message;
    logic [ByteW-1:0]   tx_data;
    logic               status_noack;
    logic               status_busy;
    logic [ByteW-1:0]   rx_data;
  } item_t;

  // One result word
  typedef struct packed {
    logic             cmd_valid;
    logic [ByteW-1:0] cmd_value;
    logic             txr_valid;
    logic [ByteW-1:0] txr_value;
    logic             rx_valid;
    logic [ByteW-1:0] rx_value;
    logic             need_tx_byte;
    logic             message_done;
    logic             transfer_done;
    status_e          status;
  } result_t;

  // Configuration seen by the sequencer
  typedef struct packed {
    logic              repeated_start_mode;
    logic [RetryW-1:0] address_retry_limit;
  } cfg_t;

endpackage

/* sv/i2c_master_transfer_sequencer.sv */
// I2C master transfer sequencer.
// Input channel (in_valid_i/in_ready_o) carries one event word: begin a
// message, a write data byte, a core command completion with its status
// bits and received byte, or a timeout. Every accepted word yields exactly
// one result word on the output channel (out_valid_o/out_ready_i): the
// command and transmit register bytes to write to the core, a received
// byte, a request for the next data byte, and done flags with a status.
// The result is registered: the result of a word accepted at a clock edge
// is on the outputs in the next cycle. The sequencer state updates in the same
// cycle, so one word is taken every cycle while the output is drained.
// The result register parts the two sides: a new word is taken while the
// held result is taken in the same cycle; when the receiver stalls with a
// result pending, in_ready_o drops until it is taken.
// The configuration channel (cfg_valid_i/cfg_ready_o) is always ready;
// index 0 writes the repeated-start mode, index 1 the address retry limit.
// Write it only while no transfer is under way.
// Reset returns to idle, empties the result register and restores
// repeated-start mode 1 and a retry limit of 5.
module i2c_master_transfer_sequencer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [i2c_mts_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  logic [i2c_mts_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [i2c_mts_pkg::FuncW-1:0]      func_i,
  input  logic [i2c_mts_pkg::AddrW-1:0]      device_address_i,
  input  logic                               read_flag_i,
  input  logic [i2c_mts_pkg::MsgLenW-1:0]    message_length_i,
  input  logic                               final_message_i,
  input  logic [i2c_mts_pkg::ByteW-1:0]      tx_data_i,
  input  logic                               status_noack_i,
  input  logic                               status_busy_i,
  input  logic [i2c_mts_pkg::ByteW-1:0]      rx_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               cmd_valid_o,
  output logic [i2c_mts_pkg::ByteW-1:0]      cmd_value_o,
  output logic                               txr_valid_o,
  output logic [i2c_mts_pkg::ByteW-1:0]      txr_value_o,
  output logic                               rx_valid_o,
  output logic [i2c_mts_pkg::ByteW-1:0]      rx_value_o,
  output logic                               need_tx_byte_o,
  output logic                               message_done_o,
  output logic                               transfer_done_o,
  output logic [i2c_mts_pkg::StatusW-1:0]    status_o
);
  import i2c_mts_pkg::*;

  cfg_t    cfg_q;
  item_t   item;
  result_t result;
  result_t result_q;
  logic    out_valid_q;
  logic    step;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.repeated_start_mode <= RepeatedStartRst;
      cfg_q.address_retry_limit <= RetryLimitRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgRepeatedStart: cfg_q.repeated_start_mode <= cfg_data_i[0];
        CfgRetryLimit:    cfg_q.address_retry_limit <= cfg_data_i[RetryW-1:0];
        default:          cfg_q <= cfg_q;
      endcase
    end
  end

  // Gather the input word
  always_comb begin
    item.func           = func_e'(func_i);
    item.device_address = device_address_i;
    item.read_flag      = read_flag_i;
    item.message_length = message_length_i;
    item.final_message  = final_message_i;
    item.tx_data        = tx_data_i;
    item.status_noack   = status_noack_i;
    item.status_busy    = status_busy_i;
    item.rx_data        = rx_data_i;
  end

  // Take a word when the result register is empty or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign step       = in_valid_i && in_ready_o;

  i2c_mts_fsm u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      result_q <= result;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cmd_valid_o     = result_q.cmd_valid;
  assign cmd_value_o     = result_q.cmd_value;
  assign txr_valid_o     = result_q.txr_valid;
  assign txr_value_o     = result_q.txr_value;
  assign rx_valid_o      = result_q.rx_valid;
  assign rx_value_o      = result_q.rx_value;
  assign need_tx_byte_o  = result_q.need_tx_byte;
  assign message_done_o  = result_q.message_done;
  assign transfer_done_o = result_q.transfer_done;
  assign status_o        = result_q.status;

endmodule

/* sv/i2c_mts_fsm.sv */
module i2c_mts_fsm (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  i2c_mts_pkg::item_t   item_i,
  input  i2c_mts_pkg::cfg_t    cfg_i,
  output i2c_mts_pkg::result_t result_o
);
  import i2c_mts_pkg::*;

  phase_e                  phase_q, phase_d;
  logic [RetryW-1:0]       retries_q, retries_d;
  logic [LENGTH_WIDTH-1:0] bytes_q, bytes_d;
  logic [ByteW-1:0]        addr_byte_q, addr_byte_d;
  logic                    reading_q, reading_d;
  logic                    last_q, last_d;
  logic                    nak_seen_q, nak_seen_d;

  logic [LENGTH_WIDTH-1:0] bytes_dec;
  logic [LENGTH_WIDTH-1:0] data_cnt;
  logic                    go_data;
  logic                    bad;
  result_t                 res;

  assign bytes_dec = bytes_q - LENGTH_WIDTH'(1);

  // Next state and result for one word
  always_comb begin
    res         = '0;
    res.status  = StOk;
    phase_d     = phase_q;
    retries_d   = retries_q;
    bytes_d     = bytes_q;
    addr_byte_d = addr_byte_q;
    reading_d   = reading_q;
    last_d      = last_q;
    nak_seen_d  = nak_seen_q;
    go_data     = 1'b0;
    data_cnt    = bytes_q;
    bad         = 1'b0;

    case (item_i.func)
      FuncTimeout: begin
        if (phase_q == PhIdle) begin
          bad = 1'b1;
        end else begin
          res.transfer_done = 1'b1;
          res.status        = StTimeout;
          phase_d           = PhIdle;
        end
      end
      FuncBegin: begin
        if (phase_q == PhIdle || phase_q == PhNext) begin
          reading_d     = item_i.read_flag;
          addr_byte_d   = {item_i.device_address, item_i.read_flag};
          bytes_d       = item_i.message_length[LENGTH_WIDTH-1:0];
          last_d        = item_i.final_message;
          retries_d     = cfg_i.address_retry_limit;
          nak_seen_d    = 1'b0;
          res.txr_valid = 1'b1;
          res.txr_value = {item_i.device_address, item_i.read_flag};
          res.cmd_valid = 1'b1;
          res.cmd_value = CmdStart | CmdWrite;
          phase_d       = PhAddr;
        end else begin
          bad = 1'b1;
        end
      end
      FuncTxByte: begin
        if (phase_q == PhWrNeed) begin
          res.txr_valid = 1'b1;
          res.txr_value = item_i.tx_data;
          res.cmd_valid = 1'b1;
          res.cmd_value = CmdWrite;
          phase_d       = PhWrWait;
        end else begin
          bad = 1'b1;
        end
      end
      default: begin
        case (phase_q)
          PhAddr: begin
            if (item_i.status_noack) begin
              res.cmd_valid = 1'b1;
              res.cmd_value = CmdStop;
              phase_d       = PhAddrStop;
            end else begin
              go_data  = 1'b1;
              data_cnt = bytes_q;
            end
          end
          PhAddrStop: begin
            if (item_i.status_busy) begin
              res.cmd_valid = 1'b1;
              res.cmd_value = CmdStop;
            end else if (retries_q != '0) begin
              retries_d     = retries_q - RetryW'(1);
              res.txr_valid = 1'b1;
              res.txr_value = addr_byte_q;
              res.cmd_valid = 1'b1;
              res.cmd_value = CmdStart | CmdWrite;
              phase_d       = PhAddr;
            end else begin
              res.transfer_done = 1'b1;
              res.status        = StAddrNak;
              phase_d           = PhIdle;
            end
          end
          PhWrWait: begin
            if (item_i.status_noack) begin
              nak_seen_d    = 1'b1;
              res.cmd_valid = 1'b1;
              res.cmd_value = CmdStop;
              phase_d       = PhWrNakStop;
            end else begin
              bytes_d  = bytes_dec;
              go_data  = 1'b1;
              data_cnt = bytes_dec;
            end
          end
          PhRdWait: begin
            res.rx_valid = 1'b1;
            res.rx_value = item_i.rx_data;
            bytes_d      = bytes_dec;
            go_data      = 1'b1;
            data_cnt     = bytes_dec;
          end
          PhWrNakStop, PhMsgStop: begin
            if (item_i.status_busy) begin
              res.cmd_valid = 1'b1;
              res.cmd_value = CmdStop;
            end else begin
              res.message_done  = 1'b1;
              res.status        = nak_seen_q ? StDataNak : StOk;
              res.transfer_done = last_q;
              phase_d           = last_q ? PhIdle : PhNext;
            end
          end
          default: begin
            bad = 1'b1;
          end
        endcase
      end
    endcase

    // Move on to the next data byte or close the message
    if (go_data) begin
      if (data_cnt == '0) begin
        if (!cfg_i.repeated_start_mode || last_q) begin
          res.cmd_valid = 1'b1;
          res.cmd_value = CmdStop;
          phase_d       = PhMsgStop;
        end else begin
          res.message_done  = 1'b1;
          res.status        = StOk;
          res.transfer_done = last_q;
          phase_d           = last_q ? PhIdle : PhNext;
        end
      end else if (reading_q) begin
        res.cmd_valid = 1'b1;
        res.cmd_value = (data_cnt == LENGTH_WIDTH'(1)) ? (CmdRead | CmdAck) : CmdRead;
        phase_d       = PhRdWait;
      end else begin
        res.need_tx_byte = 1'b1;
        phase_d          = PhWrNeed;
      end
    end

    // Drop the word and hold the state on an unexpected input
    if (bad) begin
      res         = '0;
      res.status  = StUnexpected;
      phase_d     = phase_q;
      retries_d   = retries_q;
      bytes_d     = bytes_q;
      addr_byte_d = addr_byte_q;
      reading_d   = reading_q;
      last_d      = last_q;
      nak_seen_d  = nak_seen_q;
    end
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      retries_q   <= '0;
      bytes_q     <= '0;
      addr_byte_q <= '0;
      reading_q   <= 1'b0;
      last_q      <= 1'b0;
      nak_seen_q  <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      retries_q   <= retries_d;
      bytes_q     <= bytes_d;
      addr_byte_q <= addr_byte_d;
      reading_q   <= reading_d;
      last_q      <= last_d;
      nak_seen_q  <= nak_seen_d;
    end
  end

  assign result_o = res;

endmodule

/* dv/tb_i2c_master_transfer_sequencer.sv */
module tb_i2c_master_transfer_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  import i2c_mts_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomWords = 316;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned Stages      = 6;
  localparam logic [MsgLenW-1:0] LenMask = MsgLenW'((64'd1 << LENGTH_WIDTH) - 1);

  // Sequencer state as the checker tracks it
  typedef struct packed {
    phase_e             phase;
    logic [RetryW-1:0]  retries_left;
    logic [MsgLenW-1:0] bytes_left;
    logic [ByteW-1:0]   address_byte;
    logic               reading;
    logic               last_msg;
    logic               data_nak;
  } ctl_t;

  logic                 clk_i;
  logic                 rst_ni           = 1'b0;
  logic                 cfg_valid_i      = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i      = '0;
  logic [CfgDataW-1:0]  cfg_data_i       = '0;
  logic                 in_valid_i       = 1'b0;
  logic                 in_ready_o;
  logic [FuncW-1:0]     func_i           = '0;
  logic [AddrW-1:0]     device_address_i = '0;
  logic                 read_flag_i      = 1'b0;
  logic [MsgLenW-1:0]   message_length_i = '0;
  logic                 final_message_i  = 1'b0;
  logic [ByteW-1:0]     tx_data_i        = '0;
  logic                 status_noack_i   = 1'b0;
  logic                 status_busy_i    = 1'b0;
  logic [ByteW-1:0]     rx_data_i        = '0;
  logic                 out_valid_o;
  logic                 out_ready_i      = 1'b0;
  logic                 cmd_valid_o;
  logic [ByteW-1:0]     cmd_value_o;
  logic                 txr_valid_o;
  logic [ByteW-1:0]     txr_value_o;
  logic                 rx_valid_o;
  logic [ByteW-1:0]     rx_value_o;
  logic                 need_tx_byte_o;
  logic                 message_done_o;
  logic                 transfer_done_o;
  logic [StatusW-1:0]   status_o;

  item_t   pending_words[$];
  result_t due_results[$];
  item_t   cur_word;
  logic    in_fire      = 1'b0;
  logic    hold_off     = 1'b0;
  ctl_t    master_ctl;
  ctl_t    plan_ctl;
  cfg_t    live_cfg;
  cfg_t    plan_cfg;
  int      snd_idle_pct = 0;
  int      rcv_idle_pct = 0;
  int      stage        = -1;
  int      mismatches   = 0;
  int      words_taken  = 0;
  int      rx_bytes     = 0;
  int      held_cycles  = 0;
  int      endings [5]  = '{0, 0, 0, 0, 0};
  int      cycles       = 0;

  i2c_master_transfer_sequencer DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .func_i           (func_i),
    .device_address_i (device_address_i),
    .read_flag_i      (read_flag_i),
    .message_length_i (message_length_i),
    .final_message_i  (final_message_i),
    .tx_data_i        (tx_data_i),
    .status_noack_i   (status_noack_i),
    .status_busy_i    (status_busy_i),
    .rx_data_i        (rx_data_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .cmd_valid_o      (cmd_valid_o),
    .cmd_value_o      (cmd_value_o),
    .txr_valid_o      (txr_valid_o),
    .txr_value_o      (txr_value_o),
    .rx_valid_o       (rx_valid_o),
    .rx_value_o       (rx_value_o),
    .need_tx_byte_o   (need_tx_byte_o),
    .message_done_o   (message_done_o),
    .transfer_done_o  (transfer_done_o),
    .status_o         (status_o)
  );

  // Close the current message; end the transfer on the final one
  function automatic void close_message(inout ctl_t s, inout result_t r, input status_e st);
    r.message_done = 1'b1;
    r.status = st;
    if (s.last_msg) begin
      r.transfer_done = 1'b1;
      s.phase = PhIdle;
    end else begin
      s.phase = PhNext;
    end
  endfunction

  // Send STOP unless a repeated start follows
  function automatic void end_data(inout ctl_t s, inout result_t r, input cfg_t c);
    if (!c.repeated_start_mode || s.last_msg) begin
      r.cmd_valid = 1'b1;
      r.cmd_value = CmdStop;
      s.phase = PhMsgStop;
    end else begin
      close_message(s, r, StOk);
    end
  endfunction

  // Read one byte, with ACK set on the last one
  function automatic void request_read(inout ctl_t s, inout result_t r);
    r.cmd_valid = 1'b1;
    r.cmd_value = (s.bytes_left == MsgLenW'(1)) ? (CmdRead | CmdAck) : CmdRead;
    s.phase = PhRdWait;
  endfunction

  // Move to the next data byte or wrap up the message
  function automatic void start_data(inout ctl_t s, inout result_t r, input cfg_t c);
    if (s.bytes_left == '0) begin
      end_data(s, r, c);
    end else if (s.reading) begin
      request_read(s, r);
    end else begin
      r.need_tx_byte = 1'b1;
      s.phase = PhWrNeed;
    end
  endfunction

  // Advance the sequencer by one word and return the core writes it causes
  function automatic result_t sequence_event(inout ctl_t s, input cfg_t c, input item_t w);
    result_t r;
    logic    bad;
    r = '0;
    bad = 1'b0;
    case (w.func)
      FuncTimeout: begin
        if (s.phase == PhIdle) begin
          bad = 1'b1;
        end else begin
          r.transfer_done = 1'b1;
          r.status = StTimeout;
          s.phase = PhIdle;
        end
      end
      FuncBegin: begin
        if (s.phase == PhIdle || s.phase == PhNext) begin
          s.reading = w.read_flag;
          s.address_byte = {w.device_address, w.read_flag};
          s.bytes_left = w.message_length & LenMask;
          s.last_msg = w.final_message;
          s.retries_left = c.address_retry_limit;
          s.data_nak = 1'b0;
          r.txr_valid = 1'b1;
          r.txr_value = s.address_byte;
          r.cmd_valid = 1'b1;
          r.cmd_value = CmdStart | CmdWrite;
          s.phase = PhAddr;
        end else begin
          bad = 1'b1;
        end
      end
      FuncTxByte: begin
        if (s.phase == PhWrNeed) begin
          r.txr_valid = 1'b1;
          r.txr_value = w.tx_data;
          r.cmd_valid = 1'b1;
          r.cmd_value = CmdWrite;
          s.phase = PhWrWait;
        end else begin
          bad = 1'b1;
        end
      end
      default: begin
        case (s.phase)
          PhAddr: begin
            if (w.status_noack) begin
              r.cmd_valid = 1'b1;
              r.cmd_value = CmdStop;
              s.phase = PhAddrStop;
            end else begin
              start_data(s, r, c);
            end
          end
          PhAddrStop: begin
            if (w.status_busy) begin
              r.cmd_valid = 1'b1;
              r.cmd_value = CmdStop;
            end else if (s.retries_left != '0) begin
              s.retries_left = s.retries_left - 1'b1;
              r.txr_valid = 1'b1;
              r.txr_value = s.address_byte;
              r.cmd_valid = 1'b1;
              r.cmd_value = CmdStart | CmdWrite;
              s.phase = PhAddr;
            end else begin
              r.transfer_done = 1'b1;
              r.status = StAddrNak;
              s.phase = PhIdle;
            end
          end
          PhWrWait: begin
            if (w.status_noack) begin
              s.data_nak = 1'b1;
              r.cmd_valid = 1'b1;
              r.cmd_value = CmdStop;
              s.phase = PhWrNakStop;
            end else begin
              s.bytes_left = s.bytes_left - 1'b1;
              start_data(s, r, c);
            end
          end
          PhRdWait: begin
            r.rx_valid = 1'b1;
            r.rx_value = w.rx_data;
            s.bytes_left = s.bytes_left - 1'b1;
            if (s.bytes_left == '0) begin
              end_data(s, r, c);
            end else begin
              request_read(s, r);
            end
          end
          PhWrNakStop, PhMsgStop: begin
            // only busy matters on a STOP completion
            if (w.status_busy) begin
              r.cmd_valid = 1'b1;
              r.cmd_value = CmdStop;
            end else begin
              close_message(s, r, s.data_nak ? StDataNak : StOk);
            end
          end
          default: bad = 1'b1;
        endcase
      end
    endcase
    if (bad) begin
      r = '0;
      r.status = StUnexpected;
    end
    return r;
  endfunction

  function automatic item_t random_word();
    item_t w;
    w.func           = func_e'($urandom_range(3));
    w.device_address = AddrW'($urandom);
    w.read_flag      = 1'($urandom);
    w.message_length = MsgLenW'($urandom);
    w.final_message  = 1'($urandom);
    w.tx_data        = ByteW'($urandom);
    w.status_noack   = 1'($urandom);
    w.status_busy    = 1'($urandom);
    w.rx_data        = ByteW'($urandom);
    return w;
  endfunction

  // Queue a word and track where it takes the sequencer
  task automatic plan_word(item_t w);
    void'(sequence_event(plan_ctl, plan_cfg, w));
    pending_words.push_back(w);
  endtask

  task automatic plan_fields(func_e f, logic [AddrW-1:0] a, logic rd, logic [MsgLenW-1:0] len,
                             logic fin, logic [ByteW-1:0] tx, logic nak, logic busy,
                             logic [ByteW-1:0] rx);
    item_t w;
    w = '{f, a, rd, len, fin, tx, nak, busy, rx};
    plan_word(w);
  endtask

  task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgRepeatedStart) begin
      live_cfg.repeated_start_mode = val[0];
    end else begin
      live_cfg.address_retry_limit = val;
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait until every word is taken and every result has come back
  task automatic settle();
    while (pending_words.size() != 0 || in_valid_i || due_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Drive the next word once the current one is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        cur_word = pending_words.pop_front();
        in_valid_i       <= 1'b1;
        func_i           <= cur_word.func;
        device_address_i <= cur_word.device_address;
        read_flag_i      <= cur_word.read_flag;
        message_length_i <= cur_word.message_length;
        final_message_i  <= cur_word.final_message;
        tx_data_i        <= cur_word.tx_data;
        status_noack_i   <= cur_word.status_noack;
        status_busy_i    <= cur_word.status_busy;
        rx_data_i        <= cur_word.rx_data;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Stall the result side at random, or hold off entirely
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !hold_off && ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Check each result against the oldest prediction, then predict the word taken
  always @(posedge clk_i) begin : watch
    result_t got;
    result_t want;
    in_fire = rst_ni && in_valid_i && in_ready_o;
    if (hold_off && in_valid_i && !in_ready_o) begin
      held_cycles++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.cmd_valid     = cmd_valid_o;
      got.cmd_value     = cmd_value_o;
      got.txr_valid     = txr_valid_o;
      got.txr_value     = txr_value_o;
      got.rx_valid      = rx_valid_o;
      got.rx_value      = rx_value_o;
      got.need_tx_byte  = need_tx_byte_o;
      got.message_done  = message_done_o;
      got.transfer_done = transfer_done_o;
      got.status        = status_e'(status_o);
      if (due_results.size() == 0) begin
        $error("result word with no prediction outstanding");
        mismatches++;
      end else begin
        want = due_results.pop_front();
        check_field("cmd_valid", 8'(want.cmd_valid), 8'(got.cmd_valid));
        check_field("cmd_value", want.cmd_value, got.cmd_value);
        check_field("txr_valid", 8'(want.txr_valid), 8'(got.txr_valid));
        check_field("txr_value", want.txr_value, got.txr_value);
        check_field("rx_valid", 8'(want.rx_valid), 8'(got.rx_valid));
        check_field("rx_value", want.rx_value, got.rx_value);
        check_field("need_tx_byte", 8'(want.need_tx_byte), 8'(got.need_tx_byte));
        check_field("message_done", 8'(want.message_done), 8'(got.message_done));
        check_field("transfer_done", 8'(want.transfer_done), 8'(got.transfer_done));
        check_field("status", 8'(want.status), 8'(got.status));
        if (want.message_done || want.transfer_done || want.status == StUnexpected) begin
          endings[want.status]++;
        end
        if (want.rx_valid) begin
          rx_bytes++;
        end
      end
    end
    if (in_fire) begin
      due_results.push_back(sequence_event(master_ctl, live_cfg, cur_word));
      words_taken++;
    end
  end

  // Hold the result side off long enough to back up the input
  initial begin : receiver_hold
    while (stage != 4) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin : stimulus
    bit rsm_tab [Stages]   = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
    int retry_tab [Stages] = '{5, 0, 15, 7, 15, 0};
    int snd_tab [Stages]   = '{18, 18, 69, 69, 0, 0};
    int rcv_tab [Stages]   = '{69, 69, 18, 18, 0, 0};
    item_t w;
    int roll;

    master_ctl = '0;
    master_ctl.phase = PhIdle;
    live_cfg.repeated_start_mode = RepeatedStartRst;
    live_cfg.address_retry_limit = RetryLimitRst;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int st = 0; st < Stages; st++) begin
      settle();
      snd_idle_pct = snd_tab[st];
      rcv_idle_pct = rcv_tab[st];
      stage = st;
      if (st > 0) begin
        write_reg(CfgRepeatedStart, CfgDataW'(rsm_tab[st]));
        write_reg(CfgRetryLimit, CfgDataW'(retry_tab[st]));
      end
      @(posedge clk_i);
      plan_cfg = live_cfg;
      plan_ctl = master_ctl;

      if (st == 0) begin
        // inputs nobody is waiting for in idle
        plan_fields(FuncTimeout, 7'h7f, 1'b1, 16'hffff, 1'b1, 8'hff, 1'b1, 1'b1, 8'hff);
        plan_fields(FuncTxByte, 7'h00, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00);
        plan_fields(FuncCmdDone, 7'h00, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00);
        // zero-length read, repeated start, then a timeout between messages
        plan_fields(FuncBegin, 7'h7f, 1'b1, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00);
        plan_fields(FuncCmdDone, 7'h00, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00);
        plan_fields(FuncTimeout, 7'h00, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00);
        // write with an address NAK, busy STOP, retry, a stray begin, then a data NAK
        plan_fields(FuncBegin, 7'h00, 1'b0, 16'h0002, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00);
        plan_fields(FuncCmdDone, 7'h00, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b1, 1'b0, 8'h00);
        plan_fields(FuncCmdDone, 7'h00, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b1, 8'h00);
        plan_fields(FuncCmdDone, 7'h00, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b1, 1'b0, 8'h00);
        plan_fields(FuncCmdDone, 7'h00, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b1, 8'h00);
        plan_fields(FuncBegin, 7'h12, 1'b1, 16'h0003, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00);
        plan_fields(FuncTxByte, 7'h00, 1'b0, 16'h0000, 1'b0, 8'hff, 1'b0, 1'b0, 8'h00);
        plan_fields(FuncCmdDone, 7'h00, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00);
        plan_fields(FuncTxByte, 7'h00, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00);
        plan_fields(FuncCmdDone, 7'h00, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b1, 1'b0, 8'h00);
        plan_fields(FuncCmdDone, 7'h00, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b1, 1'b0, 8'h00);
        // longest read, cut short by a timeout
        plan_fields(FuncBegin, 7'h55, 1'b1, 16'hffff, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00);
        plan_fields(FuncCmdDone, 7'h00, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00);
        plan_fields(FuncCmdDone, 7'h00, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0, 8'hff);
        plan_fields(FuncTimeout, 7'h00, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00);
        // single-byte final read with ACK and STOP
        plan_fields(FuncBegin, 7'h2a, 1'b1, 16'h0001, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00);
        plan_fields(FuncCmdDone, 7'h00, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00);
        plan_fields(FuncCmdDone, 7'h00, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00);
        plan_fields(FuncCmdDone, 7'h00, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b1, 1'b0, 8'h00);
      end else if (st == 1) begin
        // no retries left: the first address NAK ends the transfer
        plan_fields(FuncBegin, 7'h3c, 1'b0, 16'h0001, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00);
        plan_fields(FuncCmdDone, 7'h00, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b1, 1'b0, 8'h00);
        plan_fields(FuncCmdDone, 7'h00, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00);
      end

      // Mostly well-formed traffic with random content, some noise
      for (int n = 0; n < RandomWords; n++) begin
        w = random_word();
        if ($urandom_range(99) >= 5) begin
          case (plan_ctl.phase)
            PhIdle, PhNext: begin
              w.func = FuncBegin;
              w.final_message = ($urandom_range(99) < 35);
              roll = $urandom_range(99);
              if (roll < 70) begin
                w.message_length = MsgLenW'($urandom_range(3));
              end else if (roll < 90) begin
                w.message_length = MsgLenW'($urandom_range(12, 4));
              end else if (roll < 97) begin
                w.message_length = MsgLenW'($urandom_range(40, 13));
              end
            end
            PhWrNeed: w.func = FuncTxByte;
            PhAddr: begin
              w.func = FuncCmdDone;
              w.status_noack = ($urandom_range(99) < 25);
            end
            PhWrWait: begin
              w.func = FuncCmdDone;
              w.status_noack = ($urandom_range(99) < 10);
            end
            PhAddrStop, PhWrNakStop, PhMsgStop: begin
              w.func = FuncCmdDone;
              w.status_busy = ($urandom_range(99) < 25);
            end
            default: w.func = FuncCmdDone;
          endcase
        end
        plan_word(w);
      end

      // Drop back to idle so the next settings start clean
      if (plan_ctl.phase != PhIdle) begin
        w = random_word();
        w.func = FuncTimeout;
        plan_word(w);
      end
    end

    settle();
    $display("Covered %0d words over %0d register settings, %0d bytes read,",
             words_taken, Stages, rx_bytes);
    $display("%0d cycles of input stall under hold-off.", held_cycles);
    $display("Endings seen: ok %0d, address NAK %0d, data NAK %0d, timeout %0d, unexpected %0d.",
             endings[StOk], endings[StAddrNak], endings[StDataNak], endings[StTimeout],
             endings[StUnexpected]);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/i2c_mts_pkg.sv
sv/i2c_mts_fsm.sv
sv/i2c_master_transfer_sequencer.sv
dv/tb_i2c_master_transfer_sequencer.sv
